[hdl/tlsrl_pkg.sv]
`timescale 1ns / 1ps

package tlsrl_pkg;

	// fixed field widths
	localparam int unsigned PATTERN_W = 16;
	localparam int unsigned DELAY_W   = 16;

	// driver phase: write request and latch pulse
	typedef enum logic [1:0] {
		DRV_STANDBY  = 2'd0,
		DRV_LATCHING = 2'd1,
		DRV_PENDING  = 2'd2
	} drv_phase_t;

	// shift phase: data setup and clock high
	typedef enum logic [1:0] {
		SH_STANDBY = 2'd0,
		SH_STAGE   = 2'd1,
		SH_WRITE   = 2'd2
	} sh_phase_t;

endpackage

[hdl/timed_led_shift_register_loader_top.sv]
`timescale 1ns / 1ps

// Serial LED shift-register driver. Each input word is either one tick (mode 0) or a load
// of a new LED pattern (mode 1); each produces one result word with the data, clock and
// latch pin levels and a busy flag. A load requests a write that starts on the next tick:
// bits go out from bit 0, the clock rises and falls delay_ticks ticks apart, and after the
// last bit the latch is pulsed for delay_ticks ticks. One word is taken every clock cycle
// unless out_ready stalls a held result; the input register takes the word, and the single
// state-update stage then writes the result register, holding while that register is full.
// delay_ticks is written through the cfg port and should only change while no word is in
// flight.
module timed_led_shift_register_loader_top #(
	parameter int unsigned LED_COUNT = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tlsrl_pkg::DELAY_W-1:0]         cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic [tlsrl_pkg::PATTERN_W-1:0]       pattern,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  data_pin,
	output logic                                  clock_pin,
	output logic                                  latch_pin,
	output logic                                  busy_res
);

	localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam int unsigned EXT_W = 7;

	// configuration
	logic [tlsrl_pkg::DELAY_W-1:0]   delay_q;

	// input stage
	logic                            valid_s1;
	logic                            mode_s1;
	logic [tlsrl_pkg::PATTERN_W-1:0] pattern_s1;

	// result stage
	logic                            valid_s2;
	logic                            data_s2;
	logic                            clock_s2;
	logic                            latch_s2;
	logic                            busy_s2;

	// driver state
	logic [tlsrl_pkg::PATTERN_W-1:0] led_pattern_q;
	logic [IDX_W-1:0]                bit_index_q;
	logic [tlsrl_pkg::DELAY_W-1:0]   elapsed_q;
	tlsrl_pkg::drv_phase_t           drv_q;
	tlsrl_pkg::sh_phase_t            sh_q;
	logic                            data_q;
	logic                            clock_q;
	logic                            latch_q;

	// next state
	logic [tlsrl_pkg::PATTERN_W-1:0] led_pattern_nx;
	logic [IDX_W-1:0]                bit_index_nx;
	logic [tlsrl_pkg::DELAY_W-1:0]   elapsed_nx;
	tlsrl_pkg::drv_phase_t           drv_nx;
	tlsrl_pkg::sh_phase_t            sh_nx;
	logic                            data_nx;
	logic                            clock_nx;
	logic                            latch_nx;
	logic                            busy_nx;

	logic                            advance;

	// pattern bit at a shift position, zero beyond the stored width
	function automatic logic pat_bit(input logic [IDX_W-1:0] idx,
			input logic [tlsrl_pkg::PATTERN_W-1:0] pat);
		logic [EXT_W-1:0] idx_ext;
		idx_ext = EXT_W'(idx);
		if (idx_ext < EXT_W'(tlsrl_pkg::PATTERN_W)) begin
			return pat[idx_ext[3:0]];
		end
		return 1'b0;
	endfunction

	// handshakes
	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;

	// delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= tlsrl_pkg::DELAY_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			delay_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			pattern_s1 <= pattern;
		end
	end

	// one tick or one load
	always_comb begin
		led_pattern_nx = led_pattern_q;
		bit_index_nx   = bit_index_q;
		elapsed_nx     = elapsed_q;
		drv_nx         = drv_q;
		sh_nx          = sh_q;
		data_nx        = data_q;
		clock_nx       = clock_q;
		latch_nx       = latch_q;

		if (mode_s1) begin
			// load: store pattern, request a write
			led_pattern_nx = pattern_s1;
			drv_nx         = tlsrl_pkg::DRV_PENDING;
		end else begin
			// saturating tick count
			if (elapsed_q != '1) begin
				elapsed_nx = elapsed_q + tlsrl_pkg::DELAY_W'(1);
			end

			// driver phase
			case (drv_q)
				tlsrl_pkg::DRV_LATCHING: begin
					if (elapsed_nx >= delay_q) begin
						latch_nx = 1'b0;
						drv_nx   = tlsrl_pkg::DRV_STANDBY;
					end
				end
				tlsrl_pkg::DRV_PENDING: begin
					bit_index_nx = '0;
					data_nx      = pat_bit('0, led_pattern_q);
					drv_nx       = tlsrl_pkg::DRV_STANDBY;
					sh_nx        = tlsrl_pkg::SH_STAGE;
					elapsed_nx   = '0;
				end
				default: begin
				end
			endcase

			// shift phase, sees the driver's update
			case (sh_nx)
				tlsrl_pkg::SH_STAGE: begin
					if (elapsed_nx >= delay_q) begin
						clock_nx   = 1'b1;
						sh_nx      = tlsrl_pkg::SH_WRITE;
						elapsed_nx = '0;
					end
				end
				tlsrl_pkg::SH_WRITE: begin
					if (elapsed_nx >= delay_q) begin
						clock_nx = 1'b0;
						if (bit_index_nx != LAST_IDX) begin
							bit_index_nx = bit_index_nx + IDX_W'(1);
							data_nx      = pat_bit(bit_index_nx, led_pattern_q);
							sh_nx        = tlsrl_pkg::SH_STAGE;
						end else begin
							data_nx  = 1'b0;
							latch_nx = 1'b1;
							drv_nx   = tlsrl_pkg::DRV_LATCHING;
							sh_nx    = tlsrl_pkg::SH_STANDBY;
						end
						elapsed_nx = '0;
					end
				end
				default: begin
				end
			endcase
		end

		busy_nx = (drv_nx == tlsrl_pkg::DRV_LATCHING) || (drv_nx == tlsrl_pkg::DRV_PENDING) ||
			(sh_nx == tlsrl_pkg::SH_STAGE) || (sh_nx == tlsrl_pkg::SH_WRITE);
	end

	// driver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_pattern_q <= '0;
			bit_index_q   <= '0;
			elapsed_q     <= '0;
			drv_q         <= tlsrl_pkg::DRV_STANDBY;
			sh_q          <= tlsrl_pkg::SH_STANDBY;
			data_q        <= 1'b0;
			clock_q       <= 1'b0;
			latch_q       <= 1'b0;
		end else if (advance) begin
			led_pattern_q <= led_pattern_nx;
			bit_index_q   <= bit_index_nx;
			elapsed_q     <= elapsed_nx;
			drv_q         <= drv_nx;
			sh_q          <= sh_nx;
			data_q        <= data_nx;
			clock_q       <= clock_nx;
			latch_q       <= latch_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2  <= data_nx;
			clock_s2 <= clock_nx;
			latch_s2 <= latch_nx;
			busy_s2  <= busy_nx;
		end
	end

	assign out_valid = valid_s2;
	assign data_pin  = data_s2;
	assign clock_pin = clock_s2;
	assign latch_pin = latch_s2;
	assign busy_res  = busy_s2;

	// latch pulse only runs with the shifter idle
	a_latch_idle_shift: assert property (@(posedge clk) disable iff (!arst_n)
		drv_q == tlsrl_pkg::DRV_LATCHING |-> sh_q == tlsrl_pkg::SH_STANDBY)
		else $error("latch phase with shifter active");

	// a pending write is always taken up by the next tick
	a_pending_taken: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !mode_s1 |=> drv_q != tlsrl_pkg::DRV_PENDING)
		else $error("pending write survived a tick");

	// a load always reports busy
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 |=> busy_s2)
		else $error("load result not busy");

	// bit position stays within the chain
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= LAST_IDX)
		else $error("bit index past last LED");

endmodule
